FILE: rtl/core/tlps_pkg.sv
// Shared phase codes, register indexes and reset values for the traffic light sequencer.
`default_nettype none

package tlps_pkg;

   localparam int unsigned PHASE_W = 3;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned BEEP_W  = 8;
   localparam int unsigned INDEX_W = 3;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [BEEP_W-1:0]  beep_type;
   typedef logic [1:0]         resume_type;

   localparam phase_type PH_GREEN  = 3'd0;
   localparam phase_type PH_YELLOW = 3'd1;
   localparam phase_type PH_RED    = 3'd2;
   localparam phase_type PH_CLEAR  = 3'd3;
   localparam phase_type PH_WALK   = 3'd4;

   localparam logic [INDEX_W-1:0] REG_GREEN    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_YELLOW   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_RED      = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CLEAR    = 3'd3;
   localparam logic [INDEX_W-1:0] REG_BEEP_ON  = 3'd4;
   localparam logic [INDEX_W-1:0] REG_BEEP_OFF = 3'd5;
   localparam logic [INDEX_W-1:0] REG_BEEP_CNT = 3'd6;

   localparam len_type  GREEN_RST    = 16'd800;
   localparam len_type  YELLOW_RST   = 16'd200;
   localparam len_type  RED_RST      = 16'd1000;
   localparam len_type  CLEAR_RST    = 16'd500;
   localparam beep_type BEEP_ON_RST  = 8'd10;
   localparam beep_type BEEP_OFF_RST = 8'd101;
   localparam beep_type BEEP_CNT_RST = 8'd15;

   // Vehicle phase that follows p; anything past red wraps to green.
   function automatic phase_type following_phase(input phase_type p);
      phase_type r;
      if (p == PH_GREEN) begin
         r = PH_YELLOW;
      end else if (p == PH_YELLOW) begin
         r = PH_RED;
      end else begin
         r = PH_GREEN;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/traffic_light_pedestrian_sequencer_unit.sv
// Traffic light sequencer with pedestrian crossing: tick in, lamp and buzzer status out.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata[0] button_n (0 = pressed)
//  rsp     | out | rsp_tvalid/tready  | tdata[0] red, [1] green, [2] walk, [3] buzzer,
//          |     |                    |   [6:4] phase_code
//  csr     | in  | csr_valid/ready    | csr_index register, csr_data value
//
// One tick beat per cycle: the phase update and the result are computed in the
// cycle the beat is taken, and the result lands in the output register.
// A beat is taken whenever the output register is empty or being drained.
// Reset returns to green with all lengths at their defaults; csr_ready is always high.
`default_nettype none

module traffic_light_pedestrian_sequencer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,  // [0] button_n
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata,  // [0] red_lamp, [1] green_lamp,
                                                          // [2] walk_lamp, [3] buzzer_on,
                                                          // [6:4] phase_code
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tlps_pkg::INDEX_W-1:0]  csr_index,
   input  wire logic [tlps_pkg::LEN_W-1:0]    csr_data
);

   // configuration
   tlps_pkg::len_type  green_len_ff, yellow_len_ff, red_len_ff, clear_len_ff;
   tlps_pkg::beep_type beep_on_ff, beep_off_ff, beep_cnt_ff;

   // sequencer state
   tlps_pkg::phase_type  phase_ff, phase_in;
   tlps_pkg::len_type    tick_ff, tick_in;
   tlps_pkg::beep_type   beeps_ff, beeps_in;
   tlps_pkg::resume_type resume_ff, resume_in;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                pressed;
   logic                take_over;
   tlps_pkg::phase_type cur_phase;
   tlps_pkg::len_type   cur_tick;
   tlps_pkg::len_type   tick_inc;
   tlps_pkg::len_type   cur_len;
   tlps_pkg::beep_type  beeps_inc;
   logic [8:0]          beep_period;
   logic                red_l, green_l, walk_l, buzz_l;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         green_len_ff  <= tlps_pkg::GREEN_RST;
         yellow_len_ff <= tlps_pkg::YELLOW_RST;
         red_len_ff    <= tlps_pkg::RED_RST;
         clear_len_ff  <= tlps_pkg::CLEAR_RST;
         beep_on_ff    <= tlps_pkg::BEEP_ON_RST;
         beep_off_ff   <= tlps_pkg::BEEP_OFF_RST;
         beep_cnt_ff   <= tlps_pkg::BEEP_CNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tlps_pkg::REG_GREEN:    green_len_ff  <= csr_data;
            tlps_pkg::REG_YELLOW:   yellow_len_ff <= csr_data;
            tlps_pkg::REG_RED:      red_len_ff    <= csr_data;
            tlps_pkg::REG_CLEAR:    clear_len_ff  <= csr_data;
            tlps_pkg::REG_BEEP_ON:  beep_on_ff    <= csr_data[tlps_pkg::BEEP_W-1:0];
            tlps_pkg::REG_BEEP_OFF: beep_off_ff   <= csr_data[tlps_pkg::BEEP_W-1:0];
            tlps_pkg::REG_BEEP_CNT: beep_cnt_ff   <= csr_data[tlps_pkg::BEEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pressed   = !req_tdata[0];
      // a press in a vehicle phase starts the clearance on this very tick
      take_over = pressed && (phase_ff == tlps_pkg::PH_GREEN ||
                              phase_ff == tlps_pkg::PH_YELLOW ||
                              phase_ff == tlps_pkg::PH_RED);
      cur_phase = take_over ? tlps_pkg::PH_CLEAR : phase_ff;
      cur_tick  = take_over ? '0 : tick_ff;
      resume_in = take_over ? tlps_pkg::resume_type'(tlps_pkg::following_phase(phase_ff))
                            : resume_ff;

      red_l   = 1'b0;
      green_l = 1'b0;
      walk_l  = 1'b0;
      buzz_l  = 1'b0;
      cur_len = clear_len_ff;
      unique case (cur_phase)
         tlps_pkg::PH_GREEN: begin
            green_l = 1'b1;
            cur_len = green_len_ff;
         end
         tlps_pkg::PH_YELLOW: begin
            red_l   = 1'b1;
            green_l = 1'b1;
            cur_len = yellow_len_ff;
         end
         tlps_pkg::PH_RED: begin
            red_l   = 1'b1;
            cur_len = red_len_ff;
         end
         tlps_pkg::PH_CLEAR: begin
            red_l   = 1'b1;
            green_l = 1'b1;
         end
         default: begin
            red_l  = 1'b1;
            walk_l = 1'b1;
            buzz_l = cur_tick < {8'd0, beep_on_ff};
         end
      endcase
      rsp_data_in = {1'b0, cur_phase, buzz_l, walk_l, green_l, red_l};

      tick_inc    = cur_tick + 16'd1;
      beeps_inc   = beeps_ff + 8'd1;
      beep_period = {1'b0, beep_on_ff} + {1'b0, beep_off_ff};
      phase_in    = cur_phase;
      tick_in     = tick_inc;
      beeps_in    = beeps_ff;
      if (cur_phase == tlps_pkg::PH_WALK) begin
         if (tick_inc >= {7'd0, beep_period}) begin
            tick_in = '0;
            if (beeps_inc >= beep_cnt_ff) begin
               // last beep done: resume the vehicle cycle
               beeps_in = '0;
               phase_in = (resume_in == 2'd3) ? tlps_pkg::PH_GREEN : {1'b0, resume_in};
            end else begin
               beeps_in = beeps_inc;
            end
         end
      end else if (tick_inc >= cur_len) begin
         tick_in = '0;
         if (cur_phase == tlps_pkg::PH_CLEAR) begin
            phase_in = tlps_pkg::PH_WALK;
            beeps_in = '0;
         end else begin
            phase_in = tlps_pkg::following_phase(cur_phase);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tlps_pkg::PH_GREEN;
         tick_ff      <= '0;
         beeps_ff     <= '0;
         resume_ff    <= tlps_pkg::PH_YELLOW[1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            beeps_ff     <= beeps_in;
            resume_ff    <= resume_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == tlps_pkg::PH_GREEN || phase_ff == tlps_pkg::PH_YELLOW ||
      phase_ff == tlps_pkg::PH_RED || phase_ff == tlps_pkg::PH_CLEAR ||
      phase_ff == tlps_pkg::PH_WALK)
      else $error("phase register out of range");

   a_resume_vehicle: assert property (@(posedge clock) disable iff (reset)
      resume_ff != 2'd3)
      else $error("resume phase is not a vehicle phase");

   a_press_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tdata[0] && phase_ff == tlps_pkg::PH_GREEN
      |=> rsp_tdata[6:4] == tlps_pkg::PH_CLEAR)
      else $error("press in green did not start the clearance");

   a_walk_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tdata[2] |-> rsp_tdata[0] && !rsp_tdata[1])
      else $error("walk lamp lit without vehicle red");

   a_buzz_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tdata[3] |-> rsp_tdata[6:4] == tlps_pkg::PH_WALK)
      else $error("buzzer on outside the walk phase");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for the traffic light sequencer: directed table, then random ticks.

module tb;

   typedef struct packed {
      logic                pad;
      tlps_pkg::phase_type phase;
      logic                buzz;
      logic                walk;
      logic                green;
      logic                red;
   } lamp_status_type;

   typedef enum logic {ROW_TICK, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      logic                          btn_n;
      logic [tlps_pkg::INDEX_W-1:0]  idx;
      tlps_pkg::len_type             data;
      bit                            typed;
      lamp_status_type               want;
   } row_type;

   localparam logic [tlps_pkg::INDEX_W-1:0] REG_NONE = 3'd7;
   localparam lamp_status_type LAMP_GREEN = 8'h02;
   localparam lamp_status_type LAMP_CLEAR = 8'h33;
   localparam int NUM_ROWS = 38;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 200;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tlps_pkg::INDEX_W-1:0]  csr_index = '0;
   tlps_pkg::len_type             csr_data = '0;

   traffic_light_pedestrian_sequencer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Predicted sequencer state and timing registers.
   tlps_pkg::phase_type  cur_phase    = tlps_pkg::PH_GREEN;
   tlps_pkg::len_type    dwell        = '0;
   tlps_pkg::beep_type   beeps_heard  = '0;
   tlps_pkg::resume_type resume_to    = 2'(tlps_pkg::PH_YELLOW);
   tlps_pkg::len_type    green_len    = tlps_pkg::GREEN_RST;
   tlps_pkg::len_type    yellow_len   = tlps_pkg::YELLOW_RST;
   tlps_pkg::len_type    red_len      = tlps_pkg::RED_RST;
   tlps_pkg::len_type    clear_len    = tlps_pkg::CLEAR_RST;
   tlps_pkg::beep_type   beep_on_len  = tlps_pkg::BEEP_ON_RST;
   tlps_pkg::beep_type   beep_off_len = tlps_pkg::BEEP_OFF_RST;
   tlps_pkg::beep_type   beep_total   = tlps_pkg::BEEP_CNT_RST;

   lamp_status_type lamp_expect[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic tlps_pkg::phase_type phase_after(input tlps_pkg::phase_type p);
      tlps_pkg::phase_type r;
      case (p)
         tlps_pkg::PH_GREEN:  r = tlps_pkg::PH_YELLOW;
         tlps_pkg::PH_YELLOW: r = tlps_pkg::PH_RED;
         default:             r = tlps_pkg::PH_GREEN;
      endcase
      return r;
   endfunction

   function automatic tlps_pkg::len_type dwell_limit(input tlps_pkg::phase_type p);
      tlps_pkg::len_type r;
      case (p)
         tlps_pkg::PH_GREEN:  r = green_len;
         tlps_pkg::PH_YELLOW: r = yellow_len;
         tlps_pkg::PH_RED:    r = red_len;
         default:             r = clear_len;
      endcase
      return r;
   endfunction

   // Take one tick, return the lamps it shows, and move the phase on.
   function automatic lamp_status_type advance_light(input logic btn_n);
      lamp_status_type s;
      logic [tlps_pkg::LEN_W:0] beep_span;
      s = '0;
      if (cur_phase > tlps_pkg::PH_WALK) cur_phase = tlps_pkg::PH_GREEN;
      if (!btn_n && cur_phase <= tlps_pkg::PH_RED) begin
         resume_to = tlps_pkg::resume_type'(phase_after(cur_phase));
         cur_phase = tlps_pkg::PH_CLEAR;
         dwell = '0;
      end
      s.phase = cur_phase;
      case (cur_phase)
         tlps_pkg::PH_GREEN: s.green = 1'b1;
         tlps_pkg::PH_YELLOW, tlps_pkg::PH_CLEAR: begin
            s.red = 1'b1;
            s.green = 1'b1;
         end
         tlps_pkg::PH_RED: s.red = 1'b1;
         default: begin
            s.red = 1'b1;
            s.walk = 1'b1;
            s.buzz = dwell < {8'd0, beep_on_len};
         end
      endcase
      dwell = dwell + 1'b1;
      if (cur_phase == tlps_pkg::PH_WALK) begin
         beep_span = {9'd0, beep_on_len} + {9'd0, beep_off_len};
         if ({1'b0, dwell} >= beep_span) begin
            dwell = '0;
            beeps_heard = beeps_heard + 1'b1;
            if (beeps_heard >= beep_total) begin
               beeps_heard = '0;
               cur_phase = {1'b0, resume_to};
               if (cur_phase > tlps_pkg::PH_RED) cur_phase = tlps_pkg::PH_GREEN;
            end
         end
      end else if (dwell >= dwell_limit(cur_phase)) begin
         dwell = '0;
         if (cur_phase == tlps_pkg::PH_CLEAR) begin
            cur_phase = tlps_pkg::PH_WALK;
            beeps_heard = '0;
         end else begin
            cur_phase = phase_after(cur_phase);
         end
      end
      return s;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      lamp_status_type got;
      lamp_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (lamp_expect.size() == 0) begin
            $error("lamp beat with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = lamp_expect.pop_front();
            check_field("red_lamp", want.red, got.red);
            check_field("green_lamp", want.green, got.green);
            check_field("walk_lamp", want.walk, got.walk);
            check_field("buzzer_on", want.buzz, got.buzz);
            check_field("phase_code", want.phase, got.phase);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Offer one tick beat, hold it until taken, then record what it should show.
   task automatic send_tick(input logic btn_n, input bit typed, input lamp_status_type fixed);
      lamp_status_type s;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, btn_n};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      s = advance_light(btn_n);
      lamp_expect.push_back(typed ? fixed : s);
   endtask

   task automatic wait_lamps_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (lamp_expect.size() != 0);
   endtask

   task automatic write_reg(input logic [tlps_pkg::INDEX_W-1:0] idx,
                            input tlps_pkg::len_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         tlps_pkg::REG_GREEN:    green_len = val;
         tlps_pkg::REG_YELLOW:   yellow_len = val;
         tlps_pkg::REG_RED:      red_len = val;
         tlps_pkg::REG_CLEAR:    clear_len = val;
         tlps_pkg::REG_BEEP_ON:  beep_on_len = val[tlps_pkg::BEEP_W-1:0];
         tlps_pkg::REG_BEEP_OFF: beep_off_len = val[tlps_pkg::BEEP_W-1:0];
         tlps_pkg::REG_BEEP_CNT: beep_total = val[tlps_pkg::BEEP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reprogram every timing register; beep values carry junk in the upper byte.
   task automatic load_timing(input tlps_pkg::len_type g, input tlps_pkg::len_type y,
                              input tlps_pkg::len_type r, input tlps_pkg::len_type c,
                              input tlps_pkg::beep_type on, input tlps_pkg::beep_type off,
                              input tlps_pkg::beep_type cnt);
      wait_lamps_drained();
      write_reg(tlps_pkg::REG_GREEN, g);
      write_reg(tlps_pkg::REG_YELLOW, y);
      write_reg(tlps_pkg::REG_RED, r);
      write_reg(tlps_pkg::REG_CLEAR, c);
      write_reg(tlps_pkg::REG_BEEP_ON, {8'($urandom_range(0, 255)), on});
      write_reg(tlps_pkg::REG_BEEP_OFF, {8'($urandom_range(0, 255)), off});
      write_reg(tlps_pkg::REG_BEEP_CNT, {8'($urandom_range(0, 255)), cnt});
      write_reg(REG_NONE, 16'($urandom()));
   endtask

   row_type plan [NUM_ROWS] = '{
      // reset timing: green, then a press that starts the crossing
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b1, LAMP_GREEN},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b1, LAMP_CLEAR},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b1, LAMP_CLEAR},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_GREEN,    16'd3, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_YELLOW,   16'd2, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_RED,      16'd2, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_CLEAR,    16'd2, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_ON,  16'd1, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_OFF, 16'd1, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_CNT, 16'd2, 1'b0, '0},
      '{ROW_CFG,  1'b1, REG_NONE, 16'hFFFF, 1'b0, '0},
      // short timing: finish the walk, press in yellow, then in red
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b0, '0},
      // zero lengths and counts
      '{ROW_CFG,  1'b1, tlps_pkg::REG_GREEN,    16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_YELLOW,   16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_RED,      16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_CLEAR,    16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_ON,  16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_OFF, 16'd0, 1'b0, '0},
      '{ROW_CFG,  1'b1, tlps_pkg::REG_BEEP_CNT, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b0, REG_NONE, 16'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_NONE, 16'd0, 1'b0, '0}
   };

   initial begin
      int len_lim;
      int beep_lim;
      int press_pct;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (plan[i].kind == ROW_CFG) begin
            wait_lamps_drained();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_tick(plan[i].btn_n, plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         len_lim = (p % 2) ? 4 : 15;
         beep_lim = (p % 2) ? 2 : 6;
         case (p)
            1: load_timing('1, '1, '1, '1, '1, '1, '1);
            5: load_timing(16'd1, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1, 8'd1);
            default: load_timing(16'($urandom_range(0, len_lim)),
                                 16'($urandom_range(0, len_lim)),
                                 16'($urandom_range(0, len_lim)),
                                 16'($urandom_range(0, len_lim)),
                                 8'($urandom_range(0, beep_lim)),
                                 8'($urandom_range(0, beep_lim)),
                                 8'($urandom_range(0, beep_lim)));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         press_pct = $urandom_range(2, 25);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off mid-phase until every lamp beat is back
            if (n == PHASE_ITEMS / 2) wait_lamps_drained();
            send_tick($urandom_range(0, 99) >= press_pct, 1'b0, '0);
         end
      end

      wait_lamps_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && lamp_expect.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
